// File: rtl/fvdi_pkg.sv
// Shared types and constants for the face vertex dedup indexer.
// Used by every module under rtl; depends on nothing.
package fvdi_pkg;

    localparam int MAX_POSITIONS = 4096;
    localparam int BUCKET_WAYS   = 4;
    localparam int MAX_VERTICES  = 65536;
    localparam int MAX_CORNERS   = 4;
    localparam int ATTR_LIMIT    = 4096;

    localparam int REF_W   = 13;
    localparam int SG_W    = 8;
    localparam int IDX_W   = 16;
    localparam int NEXT_W  = $clog2(MAX_VERTICES + 1);
    localparam int BKT_W   = $clog2(MAX_POSITIONS);
    localparam int WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int FILL_W  = $clog2(BUCKET_WAYS + 1);
    localparam int CNT_W   = $clog2(MAX_CORNERS + 1);
    localparam int CI_W    = $clog2(MAX_CORNERS);
    localparam int IN_W    = 48;
    localparam int OUT_W   = 104;
    localparam int QDEPTH  = 2;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic [SG_W-1:0]  sg;
        logic [REF_W-1:0] tex;
        logic [REF_W-1:0] nrm;
        logic [REF_W-1:0] pos;
    } corner_t;

    typedef struct packed {
        logic                    quad;
        corner_t [MAX_CORNERS-1:0] c;
    } face_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [SG_W-1:0]  sg;
        logic [REF_W-1:0] tex;
        logic [REF_W-1:0] nrm;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_TRI1,
        ST_TRI2
    } back_state_t;

endpackage

// File: rtl/face_vertex_dedup_indexer.sv
// Top level of the face vertex dedup indexer: front, face queue and back.
// Depends on fvdi_pkg, fvdi_front, fvdi_queue and fvdi_back.
// After reset the block clears its 4096-entry bucket fill memory, one entry
// a cycle, and takes no corner until the clear is done. Corners are then taken
// one a cycle while the face queue has room. The back part picks up each
// face, then resolves each corner with a position by a bucket read state and
// a compare-and-write state, each corner without a position in the read
// state alone, and then emits one triangle record per state; a vertex or
// triangle record waits while the output is stalled.
// Output records wait in a register, and the queue holds two faces.
module face_vertex_dedup_indexer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // position_ref[12:0], normal_ref[25:13], texcoord_ref[38:26],
    // smoothing_group[46:39], zero pad [47]
    input  logic [47:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_index[15:0], vert_position[28:16], vert_normal[41:29],
    // vert_texcoord[54:42], tri_a[70:55], tri_b[86:71], tri_c[102:87],
    // overflow[103]
    output logic [103:0] m_tdata,
    output logic [0:0]   m_tuser,   // record_kind[0]
    output logic         m_tlast
);

    fvdi_pkg::corner_t corner;
    fvdi_pkg::face_t   push_face, head;
    logic              push, pop, full, not_empty, busy_clear;
    logic [fvdi_pkg::REF_W-1:0] pos_raw, nrm_raw, tex_raw;

    // drop out-of-range references to absent
    assign pos_raw    = s_tdata[12:0];
    assign nrm_raw    = s_tdata[25:13];
    assign tex_raw    = s_tdata[38:26];
    assign corner.pos = (pos_raw > fvdi_pkg::REF_W'(fvdi_pkg::MAX_POSITIONS)) ? '0 : pos_raw;
    assign corner.nrm = (nrm_raw > fvdi_pkg::REF_W'(fvdi_pkg::ATTR_LIMIT)) ? '0 : nrm_raw;
    assign corner.tex = (tex_raw > fvdi_pkg::REF_W'(fvdi_pkg::ATTR_LIMIT)) ? '0 : tex_raw;
    assign corner.sg  = s_tdata[46:39];

    fvdi_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_corner  (corner),
        .in_end     (s_tlast),
        .q_full     (full),
        .busy_clear (busy_clear),
        .push       (push),
        .push_face  (push_face)
    );

    fvdi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_face  (push_face),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    fvdi_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (not_empty),
        .face       (head),
        .pop        (pop),
        .busy_clear (busy_clear),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_kind   (m_tuser[0]),
        .out_last   (m_tlast)
    );

endmodule

// File: rtl/fvdi_front.sv
// Front part: collects corners of a face and hands complete faces to the queue.
// Depends on fvdi_pkg.
module fvdi_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fvdi_pkg::corner_t   in_corner,
    input  logic                in_end,
    input  logic                q_full,
    input  logic                busy_clear,
    output logic                push,
    output fvdi_pkg::face_t     push_face
);

    logic [fvdi_pkg::CNT_W-1:0]   count_reg, count_next;
    fvdi_pkg::corner_t [fvdi_pkg::MAX_CORNERS-1:0] store_reg, store_next;
    logic                         take;
    logic                         room;
    logic [fvdi_pkg::CNT_W-1:0]   total;

    assign in_ready = !q_full && !busy_clear;
    assign take     = in_valid && in_ready;
    assign room     = count_reg < fvdi_pkg::CNT_W'(fvdi_pkg::MAX_CORNERS);
    assign total    = room ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        push       = 1'b0;
        if (take && room)
        begin
            store_next[count_reg[fvdi_pkg::CI_W-1:0]] = in_corner;
        end
        if (take)
        begin
            if (in_end)
            begin
                count_next = '0;
                push       = total >= fvdi_pkg::CNT_W'(3);
            end
            else
            begin
                count_next = total;
            end
        end
        push_face.c    = store_next;
        push_face.quad = total == fvdi_pkg::CNT_W'(fvdi_pkg::MAX_CORNERS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

// File: rtl/fvdi_queue.sv
// Short face queue between the front and back parts.
// Depends on fvdi_pkg.
module fvdi_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fvdi_pkg::face_t   push_face,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output fvdi_pkg::face_t   head
);

    localparam int PTR_W = $clog2(fvdi_pkg::QDEPTH);

    fvdi_pkg::face_t                  slot_reg [fvdi_pkg::QDEPTH];
    logic [PTR_W-1:0]                 wr_reg, rd_reg;
    logic [PTR_W:0]                   used_reg;

    assign full      = used_reg == (PTR_W+1)'(fvdi_pkg::QDEPTH);
    assign not_empty = used_reg != '0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            used_reg <= used_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_face;
        end
    end

endmodule

// File: rtl/fvdi_back.sv
// Back part: resolves each corner through the bucket table and emits records.
// Depends on fvdi_pkg; holds the bucket and fill memories.
module fvdi_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  fvdi_pkg::face_t                   face,
    output logic                              pop,
    output logic                              busy_clear,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fvdi_pkg::OUT_W-1:0]        out_data,
    output logic                              out_kind,
    output logic                              out_last
);

    fvdi_pkg::back_state_t state_reg, state_next;

    fvdi_pkg::entry_t [fvdi_pkg::BUCKET_WAYS-1:0] bucket_mem [fvdi_pkg::MAX_POSITIONS];
    logic [fvdi_pkg::FILL_W-1:0] fill_mem [fvdi_pkg::MAX_POSITIONS];

    fvdi_pkg::entry_t [fvdi_pkg::BUCKET_WAYS-1:0] row_reg;
    logic [fvdi_pkg::FILL_W-1:0]  fill_reg;
    logic [fvdi_pkg::BKT_W-1:0]   clr_reg, clr_next;
    logic [fvdi_pkg::CI_W-1:0]    ci_reg, ci_next;
    logic [fvdi_pkg::NEXT_W-1:0]  nidx_reg, nidx_next;
    logic                         ovf_reg, ovf_next;
    logic [fvdi_pkg::IDX_W-1:0]   idx_reg [fvdi_pkg::MAX_CORNERS];
    logic [fvdi_pkg::IDX_W-1:0]   res_idx;
    logic                         res_set;

    logic                         ov_reg, ov_next;
    logic [fvdi_pkg::OUT_W-1:0]   od_reg, od_next;
    logic                         ok_reg, ok_next;
    logic                         ol_reg, ol_next;
    logic                         load_ok;

    fvdi_pkg::corner_t            cur;
    logic [fvdi_pkg::BKT_W-1:0]   bkt;
    logic                         hit;
    logic [fvdi_pkg::IDX_W-1:0]   hit_idx;
    logic                         wr_en;
    logic [fvdi_pkg::CI_W-1:0]    last_ci;
    logic [fvdi_pkg::REF_W-1:0]   zp, zn, zt;

    assign cur     = face.c[ci_reg];
    assign bkt     = fvdi_pkg::BKT_W'(cur.pos - 1'b1);
    assign load_ok = !ov_reg || out_ready;
    assign last_ci = face.quad ? fvdi_pkg::CI_W'(3) : fvdi_pkg::CI_W'(2);
    assign zp      = cur.pos - 1'b1;
    assign zn      = cur.nrm - 1'b1;
    assign zt      = cur.tex - 1'b1;

    assign busy_clear = state_reg == fvdi_pkg::ST_CLEAR;
    assign out_valid  = ov_reg;
    assign out_data   = od_reg;
    assign out_kind   = ok_reg;
    assign out_last   = ol_reg;

    // first valid way whose key matches
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = fvdi_pkg::BUCKET_WAYS - 1; k >= 0; k--)
        begin
            if (fvdi_pkg::FILL_W'(k) < fill_reg && row_reg[k].nrm == cur.nrm &&
                row_reg[k].tex == cur.tex && row_reg[k].sg == cur.sg)
            begin
                hit     = 1'b1;
                hit_idx = row_reg[k].idx;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ci_next    = ci_reg;
        nidx_next  = nidx_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        ok_next    = ok_reg;
        ol_next    = ol_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        res_set    = 1'b0;
        res_idx    = '0;
        unique case (state_reg)
            fvdi_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == fvdi_pkg::BKT_W'(fvdi_pkg::MAX_POSITIONS - 1))
                begin
                    state_next = fvdi_pkg::ST_IDLE;
                end
            end
            fvdi_pkg::ST_IDLE:
            begin
                ci_next  = '0;
                ovf_next = 1'b0;
                if (q_valid)
                begin
                    state_next = fvdi_pkg::ST_READ;
                end
            end
            fvdi_pkg::ST_READ:
            begin
                if (cur.pos == '0)
                begin
                    res_set = 1'b1;
                end
                else
                begin
                    state_next = fvdi_pkg::ST_CMP;
                end
            end
            fvdi_pkg::ST_CMP:
            begin
                if (hit)
                begin
                    res_set = 1'b1;
                    res_idx = hit_idx;
                end
                else if (fill_reg >= fvdi_pkg::FILL_W'(fvdi_pkg::BUCKET_WAYS) ||
                         nidx_reg >= fvdi_pkg::NEXT_W'(fvdi_pkg::MAX_VERTICES))
                begin
                    res_set  = 1'b1;
                    ovf_next = 1'b1;
                end
                else if (load_ok)
                begin
                    res_set   = 1'b1;
                    res_idx   = fvdi_pkg::IDX_W'(nidx_reg);
                    wr_en     = 1'b1;
                    nidx_next = nidx_reg + 1'b1;
                    ov_next   = 1'b1;
                    ok_next   = fvdi_pkg::KIND_VERTEX;
                    ol_next   = 1'b0;
                    od_next   = {1'b0, 48'd0, zt, zn, zp, fvdi_pkg::IDX_W'(nidx_reg)};
                end
            end
            fvdi_pkg::ST_TRI1:
            begin
                if (load_ok)
                begin
                    ov_next = 1'b1;
                    ok_next = fvdi_pkg::KIND_TRIANGLE;
                    ol_next = !face.quad;
                    od_next = {ovf_reg, idx_reg[2], idx_reg[1], idx_reg[0], 55'd0};
                    if (face.quad)
                    begin
                        state_next = fvdi_pkg::ST_TRI2;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        state_next = fvdi_pkg::ST_IDLE;
                    end
                end
            end
            fvdi_pkg::ST_TRI2:
            begin
                if (load_ok)
                begin
                    ov_next    = 1'b1;
                    ok_next    = fvdi_pkg::KIND_TRIANGLE;
                    ol_next    = 1'b1;
                    od_next    = {ovf_reg, idx_reg[2], idx_reg[0], idx_reg[3], 55'd0};
                    pop        = 1'b1;
                    state_next = fvdi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fvdi_pkg::ST_IDLE;
            end
        endcase
        // advance to the next corner once this one has its index
        if (res_set)
        begin
            if (ci_reg == last_ci)
            begin
                state_next = fvdi_pkg::ST_TRI1;
            end
            else
            begin
                ci_next    = ci_reg + 1'b1;
                state_next = fvdi_pkg::ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fvdi_pkg::ST_CLEAR;
            clr_reg   <= '0;
            ci_reg    <= '0;
            nidx_reg  <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ci_reg    <= ci_next;
            nidx_reg  <= nidx_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        ok_reg <= ok_next;
        ol_reg <= ol_next;
        if (res_set)
        begin
            idx_reg[ci_reg] <= res_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= bucket_mem[bkt];
        fill_reg <= fill_mem[bkt];
        if (wr_en)
        begin
            bucket_mem[bkt][fill_reg[fvdi_pkg::WAY_W-1:0]] <=
                '{idx: fvdi_pkg::IDX_W'(nidx_reg), sg: cur.sg, tex: cur.tex, nrm: cur.nrm};
        end
        if (state_reg == fvdi_pkg::ST_CLEAR)
        begin
            fill_mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            fill_mem[bkt] <= fill_reg + 1'b1;
        end
    end

endmodule

// File: tb/tb_face_vertex_dedup_indexer.sv
// Testbench for face_vertex_dedup_indexer: drives face corners on the input
// stream and checks every output record against an in-bench dedup predictor.
// Depends on fvdi_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_face_vertex_dedup_indexer;

    typedef bit bool_t;

    typedef struct packed {
        logic [12:0] pos;
        logic [12:0] nrm;
        logic [12:0] tex;
        logic [7:0]  sg;
        logic        last;
    } corner_in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] vidx;
        logic [12:0] vpos;
        logic [12:0] vnrm;
        logic [12:0] vtex;
        logic [15:0] ta;
        logic [15:0] tb;
        logic [15:0] tc;
        logic        ovf;
        logic        last;
    } record_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    face_vertex_dedup_indexer uut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [12:0] pend_pos [4];
    logic [12:0] pend_nrm [4];
    logic [12:0] pend_tex [4];
    logic [7:0]  pend_sg  [4];
    int          pend_cnt;
    logic [12:0] key_nrm [int];
    logic [12:0] key_tex [int];
    logic [7:0]  key_sg  [int];
    int          key_idx [int];
    int          bucket_used [int];
    int          next_vertex;
    record_t     expected_records [$];
    record_t     fixed_records [$];

    int mismatches = 0;
    bool_t done_sending;
    bit long_hold = 1'b0;

    function automatic logic [12:0] to_zero_based(logic [12:0] r);
        return r - 13'd1;
    endfunction

    task automatic add_record(logic kind, int vidx, logic [12:0] vp, logic [12:0] vn,
                              logic [12:0] vt, int a, int b, int c, logic ovf);
        record_t r;
        r = '{kind, vidx[15:0], vp, vn, vt, a[15:0], b[15:0], c[15:0], ovf, 1'b0};
        expected_records.insert(expected_records.size(), r);
    endtask

    task automatic resolve_corner(int c, inout logic ovf, output int idx);
        int b;
        int fill;
        int k;
        idx = 0;
        if (pend_pos[c] == 0)
            return;
        b = pend_pos[c] - 1;
        fill = bucket_used.exists(b) ? bucket_used[b] : 0;
        for (k = 0; k < fill; k++)
        begin
            if (key_nrm[b*4+k] == pend_nrm[c] && key_tex[b*4+k] == pend_tex[c]
                && key_sg[b*4+k] == pend_sg[c])
            begin
                idx = key_idx[b*4+k];
                return;
            end
        end
        if (fill >= fvdi_pkg::BUCKET_WAYS || next_vertex >= fvdi_pkg::MAX_VERTICES)
        begin
            ovf = 1'b1;
            return;
        end
        key_nrm[b*4+fill] = pend_nrm[c];
        key_tex[b*4+fill] = pend_tex[c];
        key_sg[b*4+fill] = pend_sg[c];
        key_idx[b*4+fill] = next_vertex;
        bucket_used[b] = fill + 1;
        idx = next_vertex;
        next_vertex++;
        add_record(fvdi_pkg::KIND_VERTEX, idx, to_zero_based(pend_pos[c]),
                   to_zero_based(pend_nrm[c]), to_zero_based(pend_tex[c]), 0, 0, 0, 1'b0);
    endtask

    task automatic predict_corner(corner_in_t ci);
        logic [12:0] p;
        logic [12:0] n;
        logic [12:0] t;
        int cnt;
        int idx [4];
        logic ovf;
        int i;
        p = (ci.pos > fvdi_pkg::MAX_POSITIONS) ? 13'd0 : ci.pos;
        n = (ci.nrm > fvdi_pkg::ATTR_LIMIT) ? 13'd0 : ci.nrm;
        t = (ci.tex > fvdi_pkg::ATTR_LIMIT) ? 13'd0 : ci.tex;
        if (pend_cnt < fvdi_pkg::MAX_CORNERS)
        begin
            pend_pos[pend_cnt] = p;
            pend_nrm[pend_cnt] = n;
            pend_tex[pend_cnt] = t;
            pend_sg[pend_cnt] = ci.sg;
            pend_cnt++;
        end
        if (!ci.last)
            return;
        cnt = pend_cnt;
        pend_cnt = 0;
        if (cnt < 3)
            return;
        ovf = 1'b0;
        for (i = 0; i < 4; i++)
            idx[i] = 0;
        for (i = 0; i < cnt; i++)
            resolve_corner(i, ovf, idx[i]);
        add_record(fvdi_pkg::KIND_TRIANGLE, 0, 0, 0, 0, idx[0], idx[1], idx[2], ovf);
        if (cnt == 4)
            add_record(fvdi_pkg::KIND_TRIANGLE, 0, 0, 0, 0, idx[3], idx[0], idx[2], ovf);
        expected_records[$].last = 1'b1;
    endtask

    corner_in_t corner_queue [$];

    task automatic add_face(int n, bit well_formed);
        corner_in_t c;
        int i;
        for (i = 0; i < n; i++)
        begin
            c.pos = ($urandom_range(0, 19) == 0) ? 13'($urandom) : 13'($urandom_range(1, 24));
            c.nrm = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3));
            c.tex = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3));
            c.sg = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
            c.last = well_formed ? (i == n - 1) : 1'($urandom);
            corner_queue.insert(corner_queue.size(), c);
        end
    endtask

    // sender
    initial
    begin
        corner_in_t c;
        int gap;
        int sent;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        rst_n = 1'b0;
        done_sending = 1'b0;
        pend_cnt = 0;
        next_vertex = 0;
        // directed corners: extremes, absent and out-of-range refs, short and long faces
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd1, 13'd1, 13'd1, 8'd0, 1'b0});
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd4096, 13'd4096, 13'd4096, 8'd255, 1'b0});
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd0, 13'd0, 13'd0, 8'd0, 1'b1});
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd5, 13'd0, 13'd0, 8'd1, 1'b1});
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd8191, 13'd8191, 13'd8191, 8'd7, 1'b0});
        corner_queue.insert(corner_queue.size(),
                            corner_in_t'{13'd4097, 13'd4097, 13'd4097, 8'd2, 1'b1});
        for (int k = 0; k < 6; k++)
            corner_queue.insert(corner_queue.size(),
                                corner_in_t'{13'd9, 13'd2, 13'd3, 8'(k), k == 5});
        for (int k = 0; k < 4; k++)
            corner_queue.insert(corner_queue.size(),
                                corner_in_t'{13'd1, 13'd1, 13'd1, 8'd0, k == 3});
        for (int k = 0; k < 3; k++)
            corner_queue.insert(corner_queue.size(),
                                corner_in_t'{13'd9, 13'd2, 13'd3, 8'd9, k == 2});
        // fixed expectations for the first face after reset
        fixed_records.insert(fixed_records.size(),
                             record_t'{1'b0, 16'd0, 13'd0, 13'd0, 13'd0, 16'd0, 16'd0,
                                       16'd0, 1'b0, 1'b0});
        fixed_records.insert(fixed_records.size(),
                             record_t'{1'b0, 16'd1, 13'd4095, 13'd4095, 13'd4095, 16'd0,
                                       16'd0, 16'd0, 1'b0, 1'b0});
        fixed_records.insert(fixed_records.size(),
                             record_t'{1'b1, 16'd0, 13'd0, 13'd0, 13'd0, 16'd0, 16'd1,
                                       16'd0, 1'b0, 1'b1});
        while (corner_queue.size() < 405)
        begin
            if ($urandom_range(0, 9) < 8)
                add_face($urandom_range(3, 4), 1'b1);
            else
                add_face($urandom_range(1, 6), 1'b0);
        end
        corner_queue[$].last = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        sent = 0;
        while (corner_queue.size() > 0)
        begin
            c = corner_queue.pop_front();
            gap = (sent > 150 && sent < 200) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {1'b0, c.sg, c.tex, c.nrm, c.pos};
            s_tlast <= c.last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_corner(c);
            sent++;
        end
        s_tvalid <= 1'b0;
        done_sending = 1'b1;
    end

    // receiver with a long hold-off in the middle of the run
    initial
    begin
        int gap;
        int got;
        record_t act;
        record_t exp_r;
        m_tready = 1'b0;
        got = 0;
        wait (rst_n);
        forever
        begin
            if (got == 40)
            begin
                m_tready <= 1'b0;
                long_hold = 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = (got > 120 && got < 160) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            act = '{m_tuser[0], m_tdata[15:0], m_tdata[28:16], m_tdata[41:29],
                    m_tdata[54:42], m_tdata[70:55], m_tdata[86:71], m_tdata[102:87],
                    m_tdata[103], m_tlast};
            got++;
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record %h", act);
            end
            else
            begin
                exp_r = expected_records.pop_front();
                if (fixed_records.size() > 0 && fixed_records.pop_front() != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("predictor disagrees with directed expectation %h", exp_r);
                end
                if (act != exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record mismatch: expected %h actual %h", exp_r, act);
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || long_hold)
                idle = 0;
            else
                idle++;
            if (done_sending && expected_records.size() == 0)
                break;
            if (idle >= 20000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
